FILE: rtl/ptoc_pkg.sv
// Package for the pixel to occupancy cell block: configuration and item types,
// register indexes, mode codes, cell value codes and pipeline widths.
// Depends on nothing; every other file in rtl imports it.
package ptoc_pkg;

    // Image and arithmetic widths
    localparam int MAX_DIM  = 4096;
    localparam int DIM_W    = 13;     // holds MAX_DIM itself
    localparam int POS_W    = 12;     // column and row
    localparam int IDX_W    = 24;
    localparam int SUM_W    = 10;     // up to 4 * 255
    localparam int PROD_W   = 26;     // d * 65536 and threshold * 255n
    localparam int Q_BITS   = 7;      // scaled result 0..99
    localparam int NUM_W    = PROD_W + Q_BITS;
    localparam int DIV_STAGES = Q_BITS + 1;
    localparam int SCALE_MAX  = 99;
    localparam int RECIP3     = 683;  // 2048 / 3 rounded up, exact for values below 1024
    localparam int RECIP3_SH  = 11;

    // Configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    // Register indexes
    localparam logic [2:0] REG_MAP_MODE   = 3'd0;
    localparam logic [2:0] REG_NEGATE     = 3'd1;
    localparam logic [2:0] REG_OCC_TH     = 3'd2;
    localparam logic [2:0] REG_FREE_TH    = 3'd3;
    localparam logic [2:0] REG_BPP        = 3'd4;
    localparam logic [2:0] REG_HAS_ALPHA  = 3'd5;
    localparam logic [2:0] REG_MAP_WIDTH  = 3'd6;
    localparam logic [2:0] REG_MAP_HEIGHT = 3'd7;

    // Mode codes
    localparam logic [1:0] MODE_TRINARY = 2'd0;
    localparam logic [1:0] MODE_SCALE   = 2'd1;
    localparam logic [1:0] MODE_RAW     = 2'd2;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    // Cell value codes
    localparam logic [7:0] CELL_OCCUPIED = 8'd100;
    localparam logic [7:0] CELL_FREE     = 8'd0;
    localparam logic [7:0] CELL_UNKNOWN  = 8'hFF;

    typedef struct packed {
        logic [1:0]       map_mode;
        logic             negate;
        logic [15:0]      occ_th;
        logic [15:0]      free_th;
        logic [2:0]       bpp;
        logic             has_alpha;
        logic [DIM_W-1:0] map_width;
        logic [DIM_W-1:0] map_height;
    } t_cfg;

    // Pixel as it enters the pipeline
    typedef struct packed {
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic [7:0]       chan0;
        logic [7:0]       chan1;
        logic [7:0]       chan2;
        logic [7:0]       chan3;
    } t_pixel;

    // Classified item handed from the front end to the scaling divider
    typedef struct packed {
        logic [PROD_W-1:0] a;         // d * 65536 - free_th * 255n
        logic [PROD_W-1:0] den;       // 255n * (occ_th - free_th)
        logic [7:0]        value;
        logic              need_div;
        logic [IDX_W-1:0]  idx;
        logic              oor;
    } t_item;

endpackage

FILE: rtl/pixel_to_occupancy_cell.sv
// Top level of the pixel to occupancy cell block: configuration registers and
// the eleven-stage pipeline. Depends on ptoc_pkg, ptoc_front and ptoc_div.
//
//   Port group   Role            Beat contents
//   s_axis_*     pixel in        column, row, chan0..chan3
//   m_axis_*     cell out        cell_index, cell_value; tuser out_of_range
//   APB          configuration   eight registers at byte addresses 0..28
//
// One pixel is taken every cycle while the output is not stalled; each cell passes
// three front stages (sum, products, decision) and eight divider stages
// (numerator, then one quotient bit per stage for the scaled mode).
// Synchronous reset clears the pipeline and loads the register defaults.
// A stalled output holds its beat; earlier stages keep filling bubbles, so
// s_axis_tready drops only when every stage is full.
module pixel_to_occupancy_cell (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // column[11:0], row[23:12], chan0..chan3 [55:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cell_index[23:0], cell_value[31:24]
    output logic [0:0]  m_axis_tuser,   // out_of_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ptoc_pkg::CFG_AW-1:0] paddr,
    input  logic [ptoc_pkg::CFG_DW-1:0] pwdata,
    output logic [ptoc_pkg::CFG_DW-1:0] prdata,
    output logic        pready
);
    import ptoc_pkg::*;

    t_cfg       r_cfg;
    t_pixel     w_pix;
    t_item      w_item;
    logic       w_item_valid;
    logic       w_item_ready;
    logic [2:0] w_reg;
    logic       w_write;
    logic [7:0] w_value;
    logic [IDX_W-1:0] w_idx;
    logic       w_oor;

    assign pready  = 1'b1;
    assign w_reg   = paddr[4:2];
    assign w_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_mode   <= MODE_TRINARY;
            r_cfg.negate     <= 1'b0;
            r_cfg.occ_th     <= 16'd42598;
            r_cfg.free_th    <= 16'd12779;
            r_cfg.bpp        <= 3'd1;
            r_cfg.has_alpha  <= 1'b0;
            r_cfg.map_width  <= DIM_W'(MAX_DIM);
            r_cfg.map_height <= DIM_W'(MAX_DIM);
        end else if (w_write) begin
            unique case (w_reg)
                REG_MAP_MODE:   r_cfg.map_mode   <= pwdata[1:0];
                REG_NEGATE:     r_cfg.negate     <= pwdata[0];
                REG_OCC_TH:     r_cfg.occ_th     <= pwdata[15:0];
                REG_FREE_TH:    r_cfg.free_th    <= pwdata[15:0];
                REG_BPP:        r_cfg.bpp        <= pwdata[2:0];
                REG_HAS_ALPHA:  r_cfg.has_alpha  <= pwdata[0];
                REG_MAP_WIDTH:  r_cfg.map_width  <= pwdata[DIM_W-1:0];
                REG_MAP_HEIGHT: r_cfg.map_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_MAP_MODE:   prdata = CFG_DW'(r_cfg.map_mode);
            REG_NEGATE:     prdata = CFG_DW'(r_cfg.negate);
            REG_OCC_TH:     prdata = CFG_DW'(r_cfg.occ_th);
            REG_FREE_TH:    prdata = CFG_DW'(r_cfg.free_th);
            REG_BPP:        prdata = CFG_DW'(r_cfg.bpp);
            REG_HAS_ALPHA:  prdata = CFG_DW'(r_cfg.has_alpha);
            REG_MAP_WIDTH:  prdata = CFG_DW'(r_cfg.map_width);
            REG_MAP_HEIGHT: prdata = CFG_DW'(r_cfg.map_height);
            default:        prdata = '0;
        endcase
    end

    assign w_pix.column = s_axis_tdata[11:0];
    assign w_pix.row    = s_axis_tdata[23:12];
    assign w_pix.chan0  = s_axis_tdata[31:24];
    assign w_pix.chan1  = s_axis_tdata[39:32];
    assign w_pix.chan2  = s_axis_tdata[47:40];
    assign w_pix.chan3  = s_axis_tdata[55:48];

    ptoc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pix   (w_pix),
        .o_valid (w_item_valid),
        .i_ready (w_item_ready),
        .o_item  (w_item)
    );

    ptoc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_item_valid),
        .o_ready (w_item_ready),
        .i_item  (w_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_value (w_value),
        .o_idx   (w_idx),
        .o_oor   (w_oor)
    );

    assign m_axis_tdata = {w_value, w_idx};
    assign m_axis_tuser = w_oor;

    // With the output empty, every stage can move, so a pixel is always taken.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output is empty");

    a_oor_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[23:0] == '0)
        else $error("out of range cell carries a nonzero index");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready && !s_axis_tready |=> m_axis_tvalid)
        else $error("stalled pipeline lost its output beat");

endmodule

FILE: rtl/ptoc_front.sv
// Front end of the pixel to occupancy pipeline: channel sum and darkness,
// threshold products, cell index product, then the occupied/free/unknown decision or the raw value.
// Depends on ptoc_pkg.
module ptoc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptoc_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  ptoc_pkg::t_pixel i_pix,
    output logic            o_valid,
    input  logic            i_ready,
    output ptoc_pkg::t_item o_item
);
    import ptoc_pkg::*;

    typedef struct packed {
        logic [1:0]       mode;
        logic [2:0]       n;
        logic [SUM_W-1:0] full;
        logic [SUM_W-1:0] d;
        logic [SUM_W-1:0] x;       // 255n - d, numerator of the raw average
        logic             alpha_zero;
        logic [POS_W-1:0] rows_below;
        logic [POS_W-1:0] column;
        logic [DIM_W-1:0] width;
        logic             oor;
    } t_s1;

    typedef struct packed {
        logic [1:0]        mode;
        logic              alpha_zero;
        logic [PROD_W-1:0] lhs;
        logic [PROD_W-1:0] occ_rhs;
        logic [PROD_W-1:0] free_rhs;
        logic [PROD_W-1:0] den;
        logic [7:0]        raw;
        logic [IDX_W-1:0]  idx_prod;
        logic [POS_W-1:0]  column;
        logic              oor;
    } t_s2;

    logic  r_v1, r_v2, r_v3;
    t_s1   r_s1, n_s1;
    t_s2   r_s2, n_s2;
    t_item r_s3, n_s3;
    logic  w_en1, w_en2, w_en3;

    // A stage takes a new beat when it is empty or its content moves on.
    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v3;
    assign o_item  = r_s3;

    // Stage 1: channel count, sum, darkness, range check
    always_comb begin
        logic [1:0]       mode;
        logic [2:0]       p;
        logic [2:0]       n;
        logic [SUM_W-1:0] s;
        logic [SUM_W-1:0] full;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [7:0]       last_ch;
        logic [DIM_W-1:0] below;
        mode = (i_cfg.map_mode == MODE_SPARE) ? MODE_TRINARY : i_cfg.map_mode;
        if (i_cfg.bpp == 3'd0) begin
            p = 3'd1;
        end else if (i_cfg.bpp > 3'd4) begin
            p = 3'd4;
        end else begin
            p = i_cfg.bpp;
        end
        n = (mode == MODE_TRINARY || !i_cfg.has_alpha) ? p : p - 3'd1;
        if (n == 3'd0) begin
            n = 3'd1;
        end
        s = SUM_W'(i_pix.chan0)
          + ((n >= 3'd2) ? SUM_W'(i_pix.chan1) : '0)
          + ((n >= 3'd3) ? SUM_W'(i_pix.chan2) : '0)
          + ((n >= 3'd4) ? SUM_W'(i_pix.chan3) : '0);
        full = (SUM_W'(n) << 8) - SUM_W'(n);
        case (p)
            3'd2:    last_ch = i_pix.chan1;
            3'd3:    last_ch = i_pix.chan2;
            3'd4:    last_ch = i_pix.chan3;
            default: last_ch = i_pix.chan0;
        endcase
        w = (i_cfg.map_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.map_width;
        h = (i_cfg.map_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.map_height;
        below = h - DIM_W'(1) - DIM_W'(i_pix.row);

        n_s1.mode       = mode;
        n_s1.n          = n;
        n_s1.full       = full;
        n_s1.d          = i_cfg.negate ? s : full - s;
        n_s1.x          = i_cfg.negate ? full - s : s;
        n_s1.alpha_zero = (p >= 3'd2) && (last_ch == 8'd0);
        n_s1.rows_below = below[POS_W-1:0];
        n_s1.column     = i_pix.column;
        n_s1.width      = w;
        n_s1.oor        = (DIM_W'(i_pix.column) >= w) || (DIM_W'(i_pix.row) >= h);
    end

    // Stage 2: products
    always_comb begin
        logic [15:0]          span;
        logic [SUM_W+10-1:0]  third;
        logic [DIM_W+POS_W-1:0] prod;
        span  = (i_cfg.occ_th > i_cfg.free_th) ? i_cfg.occ_th - i_cfg.free_th : 16'd0;
        third = (SUM_W+10)'(r_s1.x) * (SUM_W+10)'(RECIP3);
        prod  = (DIM_W+POS_W)'(r_s1.width) * (DIM_W+POS_W)'(r_s1.rows_below);

        n_s2.mode       = r_s1.mode;
        n_s2.alpha_zero = r_s1.alpha_zero;
        n_s2.lhs        = {r_s1.d, 16'd0};
        n_s2.occ_rhs    = PROD_W'(i_cfg.occ_th)  * PROD_W'(r_s1.full);
        n_s2.free_rhs   = PROD_W'(i_cfg.free_th) * PROD_W'(r_s1.full);
        n_s2.den        = PROD_W'(span) * PROD_W'(r_s1.full);
        case (r_s1.n)
            3'd2:    n_s2.raw = r_s1.x[8:1];
            3'd3:    n_s2.raw = third[RECIP3_SH+7:RECIP3_SH];
            3'd4:    n_s2.raw = r_s1.x[9:2];
            default: n_s2.raw = r_s1.x[7:0];
        endcase
        n_s2.idx_prod = prod[IDX_W-1:0];
        n_s2.column   = r_s1.column;
        n_s2.oor      = r_s1.oor;
    end

    // Stage 3: decision and cell index
    always_comb begin
        n_s3.a        = r_s2.lhs - r_s2.free_rhs;
        n_s3.den      = r_s2.den;
        n_s3.need_div = 1'b0;
        n_s3.oor      = r_s2.oor;
        n_s3.idx      = r_s2.oor ? '0 : r_s2.idx_prod + IDX_W'(r_s2.column);
        if (r_s2.mode == MODE_RAW) begin
            n_s3.value = r_s2.raw;
        end else if (r_s2.lhs > r_s2.occ_rhs) begin
            n_s3.value = CELL_OCCUPIED;
        end else if (r_s2.lhs < r_s2.free_rhs) begin
            n_s3.value = CELL_FREE;
        end else if (r_s2.mode == MODE_TRINARY || r_s2.alpha_zero) begin
            n_s3.value = CELL_UNKNOWN;
        end else if (r_s2.den == '0) begin
            // Thresholds equal or crossed
            n_s3.value = CELL_FREE;
        end else begin
            n_s3.value    = CELL_FREE;
            n_s3.need_div = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) r_s1 <= n_s1;
        if (w_en2 && r_v1)    r_s2 <= n_s2;
        if (w_en3 && r_v2)    r_s3 <= n_s3;
    end

endmodule

FILE: rtl/ptoc_div.sv
// Scaling stage of the pixel to occupancy pipeline: 99 * a, then a restoring
// divider by 255n * (occ_th - free_th), one quotient bit per pipeline stage.
// Depends on ptoc_pkg.
module ptoc_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ptoc_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_value,
    output logic [ptoc_pkg::IDX_W-1:0] o_idx,
    output logic            o_oor
);
    import ptoc_pkg::*;

    localparam int LAST = DIV_STAGES - 1;

    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [PROD_W-1:0] den;
        logic [Q_BITS-1:0] q;
        logic [7:0]        value;
        logic              need_div;
        logic [IDX_W-1:0]  idx;
        logic              oor;
    } t_dstage;

    logic    r_v  [DIV_STAGES];
    t_dstage r_st [DIV_STAGES];
    logic    w_en [DIV_STAGES];

    always_comb begin
        w_en[LAST] = !r_v[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[LAST];
    assign o_value = r_st[LAST].need_div ? 8'(r_st[LAST].q) : r_st[LAST].value;
    assign o_idx   = r_st[LAST].idx;
    assign o_oor   = r_st[LAST].oor;

    // Stage 0 forms the numerator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0] && i_valid) begin
            r_st[0].rem      <= NUM_W'(i_item.a) * NUM_W'(SCALE_MAX);
            r_st[0].den      <= i_item.den;
            r_st[0].q        <= '0;
            r_st[0].value    <= i_item.value;
            r_st[0].need_div <= i_item.need_div;
            r_st[0].idx      <= i_item.idx;
            r_st[0].oor      <= i_item.oor;
        end
    end

    // Each later stage settles one quotient bit, most significant first.
    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_bit
        logic [NUM_W-1:0] w_shift;
        logic             w_take;

        assign w_shift = NUM_W'(r_st[k-1].den) << (Q_BITS - k);
        assign w_take  = r_st[k-1].rem >= w_shift;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k] && r_v[k-1]) begin
                r_st[k].rem      <= w_take ? r_st[k-1].rem - w_shift : r_st[k-1].rem;
                r_st[k].den      <= r_st[k-1].den;
                r_st[k].q        <= {r_st[k-1].q[Q_BITS-2:0], w_take};
                r_st[k].value    <= r_st[k-1].value;
                r_st[k].need_div <= r_st[k-1].need_div;
                r_st[k].idx      <= r_st[k-1].idx;
                r_st[k].oor      <= r_st[k-1].oor;
            end
        end
    end

    // A scaled cell never exceeds 99 since a is at most the divisor.
    a_q_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] && r_st[LAST].need_div |-> r_st[LAST].q <= Q_BITS'(SCALE_MAX))
        else $error("scaled cell value above 99");

    a_rem_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] && r_st[LAST].need_div |-> r_st[LAST].rem < NUM_W'(r_st[LAST].den))
        else $error("divider remainder not below divisor");

    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && r_st[0].need_div |-> r_st[0].den != '0)
        else $error("division requested with zero divisor");

endmodule
